// ===== design/tbrk4_pkg.sv =====
// Shared types and constants for the two-body RK4 propagator.
package tbrk4_pkg;

    localparam logic [63:0] MU_VAL      = 64'd398600441800000;
    localparam logic [47:0] ONE_METRE   = 48'd65536;
    localparam logic [46:0] MAX_MAG47   = {47{1'b1}};
    // (2^63 + 1) / 3: floor(y * RECIP_THREE / 2^63) = floor(y / 3) for y below 2^63
    localparam logic [63:0] RECIP_THREE = 64'h2AAA_AAAA_AAAA_AAAB;

    localparam logic [2:0] CFG_POS_X = 3'd0;
    localparam logic [2:0] CFG_POS_Y = 3'd1;
    localparam logic [2:0] CFG_POS_Z = 3'd2;
    localparam logic [2:0] CFG_VEL_X = 3'd3;
    localparam logic [2:0] CFG_VEL_Y = 3'd4;
    localparam logic [2:0] CFG_VEL_Z = 3'd5;

    typedef struct packed {
        logic        action;
        logic [23:0] step_seconds;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [47:0] vel_x;
        logic signed [47:0] vel_y;
        logic signed [47:0] vel_z;
    } out_item_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_MUDIV,
        ST_GDIV,
        ST_GMUL,
        ST_ADIV,
        ST_PMUL,
        ST_VMUL,
        ST_FPMUL,
        ST_FPDIV,
        ST_FVMUL,
        ST_FVDIV,
        ST_PUT
    } tbrk4_state_t;

endpackage

// ===== design/tbrk4_unit.sv =====
// Shared iterative unit: radix-2^16 multiply, restoring divide, digit square root.
module tbrk4_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbrk4_pkg::unit_cmd_t cmd,
    input  logic [127:0]         opa,
    input  logic [63:0]          opb,
    output logic [127:0]         result,
    output logic                 done
);
    import tbrk4_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    unit_op_t     op_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] x_reg;
    logic [127:0] r_reg;
    logic [63:0]  y_reg;

    logic [79:0]  prod_digit;
    logic [127:0] mul_next;
    logic [48:0]  rem_sh;
    logic [48:0]  div_d;
    logic         div_ge;
    logic [48:0]  rem_new;
    logic [51:0]  sq_sh;
    logic [51:0]  sq_trial;
    logic         sq_ge;
    logic [51:0]  sq_rem;

    assign prod_digit = x_reg[63:0] * y_reg[63:48];
    assign mul_next   = {r_reg[111:0], 16'b0} + {48'b0, prod_digit};
    assign rem_sh     = {r_reg[47:0], x_reg[127]};
    assign div_d      = {1'b0, y_reg[47:0]};
    assign div_ge     = rem_sh >= div_d;
    assign rem_new    = div_ge ? rem_sh - div_d : rem_sh;
    assign sq_sh      = {r_reg[49:0], x_reg[127:126]};
    assign sq_trial   = {2'b0, y_reg[47:0], 2'b01};
    assign sq_ge      = sq_sh >= sq_trial;
    assign sq_rem     = sq_ge ? sq_sh - sq_trial : sq_sh;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= UOP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                case (cmd.op)
                    UOP_MUL:  cnt_reg <= 7'd3;
                    UOP_DIV:  cnt_reg <= 7'd127;
                    UOP_SQRT: cnt_reg <= 7'd47;
                    default:  cnt_reg <= 7'd0;
                endcase
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= opa;
            y_reg <= (cmd.op == UOP_SQRT) ? 64'b0 : opb;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                UOP_MUL:
                begin
                    r_reg <= mul_next;
                    y_reg <= {y_reg[47:0], 16'b0};
                end
                UOP_DIV:
                begin
                    r_reg <= {80'b0, rem_new[47:0]};
                    x_reg <= {x_reg[126:0], div_ge};
                end
                UOP_SQRT:
                begin
                    r_reg <= {78'b0, sq_rem[49:0]};
                    y_reg <= {16'b0, y_reg[46:0], sq_ge};
                    x_reg <= {x_reg[125:0], 2'b00};
                end
                default:
                begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            UOP_MUL:  result = r_reg;
            UOP_DIV:  result = x_reg;
            UOP_SQRT: result = {64'b0, y_reg};
            default:  result = '0;
        endcase
    end

    assign done = done_reg;

endmodule

// ===== design/two_body_rk4_propagator_top.sv =====
// Two-body RK4 orbit propagator: sequencer, state registers and ports.
// Load item: start values are copied into position and velocity, then sent out from ST_PUT.
// Step item: its duration is set by the shared unit (five divides per gravity evaluation,
// one square root per evaluation, multiplies; the final divides by six are multiplies).
// One item at a time; a new item is taken while the previous result waits at the output.
// Reset (async, active low) clears start registers, position and velocity to zero.
module two_body_rk4_propagator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tbrk4_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tbrk4_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [47:0]          cfg_data
);
    import tbrk4_pkg::*;

    function automatic logic [47:0] mag48(input logic [47:0] v);
        mag48 = v[47] ? (~v + 48'd1) : v;
    endfunction

    function automatic logic [51:0] mag52(input logic [51:0] v);
        mag52 = v[51] ? (~v + 52'd1) : v;
    endfunction

    // base plus signed magnitude, clipped to the 48-bit range
    function automatic logic [47:0] sat_add(input logic [47:0] base, input logic [63:0] m,
                                            input logic neg);
        logic [63:0] sum;
        sum = {{16{base[47]}}, base} + (neg ? (~m + 64'd1) : m);
        if (!sum[63] && (|sum[62:47]))
            sat_add = {1'b0, {47{1'b1}}};
        else if (sum[63] && !(&sum[62:47]))
            sat_add = {1'b1, 47'b0};
        else
            sat_add = sum[47:0];
    endfunction

    tbrk4_state_t state_reg, state_next;
    logic         wait_reg;
    logic [1:0]   axis_reg;
    logic [1:0]   stage_reg;

    logic [47:0]  start_reg   [6];
    logic [47:0]  cur_pos_reg [3];
    logic [47:0]  cur_vel_reg [3];
    logic [47:0]  ps_reg      [3];
    logic [47:0]  kr_reg      [3];
    logic [47:0]  kv_reg      [3];
    logic [51:0]  sr_reg      [3];
    logic [51:0]  sv_reg      [3];
    logic [95:0]  r2_reg;
    logic [47:0]  root_reg;
    logic [127:0] t_reg;
    logic [63:0]  g_reg;
    logic [23:0]  h_reg;
    out_item_t    out_reg;
    logic         out_valid_reg;

    unit_cmd_t    u_cmd;
    logic [127:0] u_opa;
    logic [63:0]  u_opb;
    logic [127:0] u_res;
    logic         u_done;
    logic         fin;
    logic         busy_state;
    logic         put_go;

    logic [47:0]  ps_sel, kr_sel, kv_sel, ps_mag;
    logic [51:0]  sr_sel, sv_sel;
    logic [46:0]  acc_mag;
    logic [47:0]  acc_val;
    logic         ps_pos;
    logic [63:0]  p_shift, v_shift;
    logic [47:0]  kr_new;
    logic         dbl;
    logic         dbl_kr;

    tbrk4_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (u_cmd),
        .opa    (u_opa),
        .opb    (u_opb),
        .result (u_res),
        .done   (u_done)
    );

    assign ps_sel  = ps_reg[axis_reg];
    assign kr_sel  = kr_reg[axis_reg];
    assign kv_sel  = kv_reg[axis_reg];
    assign sr_sel  = sr_reg[axis_reg];
    assign sv_sel  = sv_reg[axis_reg];
    assign ps_mag  = mag48(ps_sel);
    assign ps_pos  = !ps_sel[47] && (|ps_sel);
    assign acc_mag = (|u_res[127:47]) ? MAX_MAG47 : u_res[46:0];
    assign acc_val = ps_pos ? (~{1'b0, acc_mag} + 48'd1) : {1'b0, acc_mag};
    assign p_shift = (stage_reg == 2'd2) ? u_res[95:32] : u_res[96:33];
    assign v_shift = (stage_reg == 2'd2) ? u_res[79:16] : u_res[80:17];
    assign kr_new  = sat_add(cur_vel_reg[axis_reg], v_shift, kv_sel[47]);
    assign dbl     = (stage_reg == 2'd1) || (stage_reg == 2'd2);
    assign dbl_kr  = (stage_reg != 2'd2);

    assign fin        = wait_reg && u_done;
    assign busy_state = (state_reg != ST_IDLE) && (state_reg != ST_PUT);
    assign put_go     = (state_reg == ST_PUT) && (!out_valid_reg || !out_stall);

    // operand select for the shared unit
    always_comb
    begin
        u_cmd.start = busy_state && !wait_reg;
        u_cmd.op    = UOP_MUL;
        u_opa       = '0;
        u_opb       = '0;
        case (state_reg)
            ST_SQ:
            begin
                u_opa = {80'b0, ps_mag};
                u_opb = {16'b0, ps_mag};
            end
            ST_ROOT:
            begin
                u_cmd.op = UOP_SQRT;
                u_opa    = {r2_reg, 32'b0};
            end
            ST_MUDIV:
            begin
                u_cmd.op = UOP_DIV;
                u_opa    = {MU_VAL, 64'b0};
                u_opb    = {16'b0, root_reg};
            end
            ST_GDIV, ST_ADIV:
            begin
                u_cmd.op = UOP_DIV;
                u_opa    = t_reg;
                u_opb    = {16'b0, root_reg};
            end
            ST_GMUL:
            begin
                u_opa = {64'b0, g_reg};
                u_opb = {16'b0, ps_mag};
            end
            ST_PMUL:
            begin
                u_opa = {80'b0, mag48(kr_sel)};
                u_opb = {40'b0, h_reg};
            end
            ST_VMUL:
            begin
                u_opa = {80'b0, mag48(kv_sel)};
                u_opb = {40'b0, h_reg};
            end
            ST_FPMUL:
            begin
                u_opa = {76'b0, mag52(sr_sel)};
                u_opb = {40'b0, h_reg};
            end
            ST_FVMUL:
            begin
                u_opa = {76'b0, mag52(sv_sel)};
                u_opb = {40'b0, h_reg};
            end
            // divide by six: halve, then multiply by the reciprocal of three
            ST_FPDIV:
            begin
                u_opa = {65'b0, t_reg[95:33]};
                u_opb = RECIP_THREE;
            end
            ST_FVDIV:
            begin
                u_opa = {65'b0, t_reg[79:17]};
                u_opb = RECIP_THREE;
            end
            default:
            begin
                u_cmd.op = UOP_MUL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = in_data.action ? ST_SQ : ST_PUT;
            ST_SQ:
                if (fin && axis_reg == 2'd2)
                    state_next = ST_ROOT;
            ST_ROOT:
                if (fin)
                    state_next = ST_MUDIV;
            ST_MUDIV:
                if (fin)
                    state_next = ST_GDIV;
            ST_GDIV:
                if (fin)
                    state_next = ST_GMUL;
            ST_GMUL:
                if (fin)
                    state_next = ST_ADIV;
            ST_ADIV:
                if (fin)
                begin
                    if (axis_reg != 2'd2)
                        state_next = ST_GMUL;
                    else
                        state_next = (stage_reg == 2'd3) ? ST_FPMUL : ST_PMUL;
                end
            ST_PMUL:
                if (fin)
                    state_next = ST_VMUL;
            ST_VMUL:
                if (fin)
                    state_next = (axis_reg == 2'd2) ? ST_SQ : ST_PMUL;
            ST_FPMUL:
                if (fin)
                    state_next = ST_FPDIV;
            ST_FPDIV:
                if (fin)
                    state_next = ST_FVMUL;
            ST_FVMUL:
                if (fin)
                    state_next = ST_FVDIV;
            ST_FVDIV:
                if (fin)
                    state_next = (axis_reg == 2'd2) ? ST_PUT : ST_FPMUL;
            ST_PUT:
                if (put_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control: handshake with the unit, counters, output valid, state and config
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wait_reg      <= 1'b0;
            axis_reg      <= 2'd0;
            stage_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                start_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cur_pos_reg[i] <= '0;
                cur_vel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_POS_X: start_reg[0] <= cfg_data;
                    CFG_POS_Y: start_reg[1] <= cfg_data;
                    CFG_POS_Z: start_reg[2] <= cfg_data;
                    CFG_VEL_X: start_reg[3] <= cfg_data;
                    CFG_VEL_Y: start_reg[4] <= cfg_data;
                    CFG_VEL_Z: start_reg[5] <= cfg_data;
                    default:   start_reg[0] <= start_reg[0];
                endcase
            end

            if (u_cmd.start)
                wait_reg <= 1'b1;
            else if (fin)
                wait_reg <= 1'b0;

            if (put_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_IDLE && in_valid)
            begin
                axis_reg  <= 2'd0;
                stage_reg <= 2'd0;
                if (!in_data.action)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cur_pos_reg[i] <= start_reg[i];
                        cur_vel_reg[i] <= start_reg[3 + i];
                    end
                end
            end

            if (fin)
            begin
                case (state_reg)
                    ST_SQ, ST_ADIV, ST_FVDIV:
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    ST_VMUL:
                    begin
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                            stage_reg <= stage_reg + 2'd1;
                    end
                    ST_FPDIV:
                        cur_pos_reg[axis_reg] <= sat_add(cur_pos_reg[axis_reg], u_res[126:63],
                                                         sr_sel[51]);
                    default:
                        axis_reg <= axis_reg;
                endcase
                if (state_reg == ST_FVDIV)
                    cur_vel_reg[axis_reg] <= sat_add(cur_vel_reg[axis_reg], u_res[126:63],
                                                     sv_sel[51]);
            end
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_data.action)
        begin
            h_reg <= in_data.step_seconds;
            for (int i = 0; i < 3; i++)
            begin
                ps_reg[i] <= cur_pos_reg[i];
                kr_reg[i] <= cur_vel_reg[i];
                sr_reg[i] <= {{4{cur_vel_reg[i][47]}}, cur_vel_reg[i]};
                sv_reg[i] <= '0;
            end
        end

        // hold the waiting item until the receiver takes it
        if (put_go)
        begin
            out_reg.pos_x <= cur_pos_reg[0];
            out_reg.pos_y <= cur_pos_reg[1];
            out_reg.pos_z <= cur_pos_reg[2];
            out_reg.vel_x <= cur_vel_reg[0];
            out_reg.vel_y <= cur_vel_reg[1];
            out_reg.vel_z <= cur_vel_reg[2];
        end

        if (fin)
        begin
            case (state_reg)
                ST_SQ:
                    r2_reg <= ((axis_reg == 2'd0) ? 96'b0 : r2_reg) + u_res[95:0];
                ST_ROOT:
                    root_reg <= (u_res[47:0] < ONE_METRE) ? ONE_METRE : u_res[47:0];
                ST_MUDIV, ST_GMUL, ST_FPMUL, ST_FVMUL:
                    t_reg <= u_res;
                ST_GDIV:
                    g_reg <= (|u_res[127:64]) ? {64{1'b1}} : u_res[63:0];
                ST_ADIV:
                begin
                    kv_reg[axis_reg] <= acc_val;
                    sv_reg[axis_reg] <= sv_sel + (dbl ? {{3{acc_val[47]}}, acc_val, 1'b0}
                                                      : {{4{acc_val[47]}}, acc_val});
                end
                ST_PMUL:
                    ps_reg[axis_reg] <= sat_add(cur_pos_reg[axis_reg], p_shift, kr_sel[47]);
                ST_VMUL:
                begin
                    kr_reg[axis_reg] <= kr_new;
                    sr_reg[axis_reg] <= sr_sel + (dbl_kr ? {{3{kr_new[47]}}, kr_new, 1'b0}
                                                         : {{4{kr_new[47]}}, kr_new});
                end
                default:
                    h_reg <= h_reg;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted without blocking the next one");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> wait_reg)
        else $error("unit finished with no operation outstanding");

    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wait_reg)
        else $error("idle while unit operation outstanding");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

endmodule
